@@ rtl/msct_pkg.sv @@
// Shared types, constants and helpers for the multi-slot countdown timer.
package msct_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int MEM_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W     = 32;

    localparam logic [CNT_W-1:0] INACTIVE_COUNT = '1;
    localparam logic [30:0]      NO_DEADLINE    = 31'h7FFF_FFFF;
    localparam logic signed [CNT_W-1:0] PRIME_LIMIT = -32'sd30;

    // x / 1000 == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for every 32-bit x
    localparam int               DIV_MAGIC_W   = 29;
    localparam logic [DIV_MAGIC_W-1:0] DIV1000_MAGIC = 29'h1062_4DD3;
    localparam int               DIV1000_SHIFT = 38;
    localparam int               PROD_W        = CNT_W + DIV_MAGIC_W;
    localparam int               QUO_W         = PROD_W - DIV1000_SHIFT;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_PRIME  = 2'd2,
        FUNC_TICK   = 2'd3
    } msct_func_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_REPORT  = 2'd2
    } msct_kind_t;

    typedef struct packed {
        msct_func_t         func;
        logic [3:0]         slot;
        logic signed [31:0] request_count;
        logic [15:0]        elapsed_ms;
    } msct_cmd_t;

    typedef struct packed {
        msct_kind_t  kind;
        logic [3:0]  fired_slot;
        logic [30:0] next_deadline;
        logic        has_deadline;
        logic        last;
    } msct_rsp_t;

    function automatic logic slot_in_range(input logic [3:0] slot);
        slot_in_range = (32'(slot) < NUM_SLOTS);
    endfunction

endpackage

@@ rtl/msct_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module msct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/msct_prime.sv @@
// Prime delay: negative us to ms by reciprocal multiply, clamp, add elapsed.
module msct_prime
    import msct_pkg::*;
(
    input  logic                    clk,
    input  logic signed [CNT_W-1:0] request_count,
    input  logic [15:0]             elapsed_ms,
    output logic [CNT_W-1:0]        count
);

    // stage 1: magnitude and flags
    logic [CNT_W-1:0]        mag_reg;
    logic                    small_reg;
    logic signed [CNT_W-1:0] req_reg;
    logic [15:0]             el1_reg;
    // stage 2: product
    logic [PROD_W-1:0]       prod_reg;
    logic                    small2_reg;
    logic signed [CNT_W-1:0] req2_reg;
    logic [15:0]             el2_reg;

    logic [QUO_W-1:0] quo;
    logic [CNT_W-1:0] ms;

    always_ff @(posedge clk)
    begin
        mag_reg    <= CNT_W'(0) - CNT_W'(request_count);
        small_reg  <= (request_count < PRIME_LIMIT);
        req_reg    <= request_count;
        el1_reg    <= elapsed_ms;
        prod_reg   <= PROD_W'(mag_reg) * PROD_W'(DIV1000_MAGIC);
        small2_reg <= small_reg;
        req2_reg   <= req_reg;
        el2_reg    <= el1_reg;
    end

    assign quo = prod_reg[PROD_W-1:DIV1000_SHIFT];

    always_comb
    begin
        if (small2_reg)
        begin
            ms = (quo == '0) ? CNT_W'(1) : CNT_W'(quo);
        end
        else
        begin
            ms = (req2_reg <= 0) ? CNT_W'(1) : CNT_W'(req2_reg);
        end
    end

    assign count = ms + CNT_W'(el2_reg);

endmodule

@@ rtl/multi_slot_countdown_timer_core.sv @@
// Top level of the multi-slot countdown timer: sequencer around the count RAM.
//
//  channel   | ports                    | transfer
//  ----------+--------------------------+--------------------------------------
//  command   | start, busy, cmd         | taken at edge with start & !busy
//  response  | result_valid, rsp        | one-cycle strobe, taken at that edge
//
// Insert and remove: ack strobed the cycle after the command is taken, busy never rises.
// Prime: busy through ST_PRM_MUL and ST_PRM_WR while the us-to-ms multiply settles;
// ack with the write-back. Tick: the count RAM read port scans one slot per
// cycle, expired slots strobe as they are found, then the deadline.
// Reset clears the state machine, strobe and present flags, not the count RAM.
// The response side cannot stall; each transaction is taken in its strobe cycle.
module multi_slot_countdown_timer_core
    import msct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  msct_cmd_t cmd,
    output logic      result_valid,
    output msct_rsp_t rsp
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRM_MUL,
        ST_PRM_WR,
        ST_SCAN,
        ST_FINAL
    } state_t;

    state_t                 state_reg, state_next;
    logic [MEM_AW-1:0]      idx_reg, idx_next;
    logic [NUM_SLOTS-1:0]   present_reg, present_next;
    logic [30:0]            best_reg, best_next;
    logic                   any_reg, any_next;
    logic                   result_valid_reg, result_valid_next;
    msct_rsp_t              rsp_reg, rsp_next;
    msct_cmd_t              cmd_reg;

    logic                   accept;
    logic                   ram_we;
    logic [MEM_AW-1:0]      ram_waddr, ram_raddr;
    logic [CNT_W-1:0]       ram_wdata, ram_rdata;
    logic [CNT_W-1:0]       prime_count;
    logic signed [CNT_W-1:0] cur_cnt, dec_cnt;

    assign busy         = (state_reg != ST_IDLE);
    assign accept       = start && !busy;
    assign result_valid = result_valid_reg;
    assign rsp          = rsp_reg;

    msct_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_SLOTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // prime pipeline samples the command every cycle; its count is valid in ST_PRM_WR
    msct_prime u_prime (
        .clk           (clk),
        .request_count (cmd.request_count),
        .elapsed_ms    (cmd.elapsed_ms),
        .count         (prime_count)
    );

    // scan datapath: slot idx_reg has its count on the RAM read port
    assign cur_cnt = signed'(ram_rdata);
    assign dec_cnt = cur_cnt - signed'(CNT_W'(cmd_reg.elapsed_ms));

    always_comb
    begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        present_next      = present_reg;
        best_next         = best_reg;
        any_next          = any_reg;
        result_valid_next = 1'b0;
        rsp_next          = '0;
        ram_we            = 1'b0;
        ram_waddr         = MEM_AW'(cmd.slot);
        ram_wdata         = INACTIVE_COUNT;
        ram_raddr         = idx_reg + MEM_AW'(1);   // prefetch next slot

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = '0;
                if (start)
                begin
                    case (cmd.func)
                        FUNC_INSERT:
                        begin
                            if (slot_in_range(cmd.slot))
                            begin
                                ram_we = 1'b1;
                                present_next[MEM_AW'(cmd.slot)] = 1'b1;
                            end
                            result_valid_next = 1'b1;
                            rsp_next.kind     = KIND_ACK;
                            rsp_next.last     = 1'b1;
                        end
                        FUNC_REMOVE:
                        begin
                            if (slot_in_range(cmd.slot))
                            begin
                                present_next[MEM_AW'(cmd.slot)] = 1'b0;
                            end
                            result_valid_next = 1'b1;
                            rsp_next.kind     = KIND_ACK;
                            rsp_next.last     = 1'b1;
                        end
                        FUNC_PRIME:
                        begin
                            state_next = ST_PRM_MUL;
                        end
                        FUNC_TICK:
                        begin
                            idx_next   = '0;
                            best_next  = NO_DEADLINE;
                            any_next   = 1'b0;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_PRM_MUL:
            begin
                state_next = ST_PRM_WR;
            end

            ST_PRM_WR:
            begin
                ram_waddr = MEM_AW'(cmd_reg.slot);
                ram_wdata = prime_count;
                ram_we    = slot_in_range(cmd_reg.slot);
                result_valid_next = 1'b1;
                rsp_next.kind     = KIND_ACK;
                rsp_next.last     = 1'b1;
                state_next        = ST_IDLE;
            end

            ST_SCAN:
            begin
                // write-back hits idx_reg while the read already moved on,
                // so the same entry is never read and written in the same cycle
                ram_waddr = idx_reg;
                ram_wdata = CNT_W'(dec_cnt);
                if (present_reg[idx_reg] && (cur_cnt > 0))
                begin
                    ram_we = 1'b1;
                    if (dec_cnt <= 0)
                    begin
                        result_valid_next   = 1'b1;
                        rsp_next.kind       = KIND_EXPIRED;
                        rsp_next.fired_slot = 4'(idx_reg);
                    end
                    else
                    begin
                        any_next = 1'b1;
                        if (dec_cnt[30:0] < best_reg)
                        begin
                            best_next = dec_cnt[30:0];
                        end
                    end
                end
                idx_next = idx_reg + MEM_AW'(1);
                if (idx_reg == MEM_AW'(NUM_SLOTS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                result_valid_next      = 1'b1;
                rsp_next.kind          = KIND_REPORT;
                rsp_next.next_deadline = best_reg;
                rsp_next.has_deadline  = any_reg;
                rsp_next.last          = 1'b1;
                state_next             = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            idx_reg          <= '0;
            present_reg      <= '0;
            best_reg         <= NO_DEADLINE;
            any_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            rsp_reg          <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            idx_reg          <= idx_next;
            present_reg      <= present_next;
            best_reg         <= best_next;
            any_reg          <= any_next;
            result_valid_reg <= result_valid_next;
            rsp_reg          <= rsp_next;
        end
    end

    // held command: slot and elapsed time for prime and tick
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
    end

    // a tick always takes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (cmd.func == FUNC_TICK) |=> busy)
        else $error("tick accepted without entering scan");

    // expired reports are never the final transaction of a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (rsp.kind == KIND_EXPIRED) |-> !rsp.last)
        else $error("expired report marked last");

    // the deadline report closes the tick; block is free again
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (rsp.kind == KIND_REPORT) |-> rsp.last && !busy)
        else $error("deadline report while still busy");

    // with no positive count the deadline reads as the empty marker
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (rsp.kind == KIND_REPORT) && !rsp.has_deadline
        |-> (rsp.next_deadline == NO_DEADLINE))
        else $error("deadline set with no active slot");

endmodule
